/* src/rck_pkg.sv */
package rck_pkg;

    // line store depth per row, and its address width
    localparam int MaxLine   = 1024;
    localparam int MaxKernel = 3;
    localparam int AddrW     = $clog2(MaxLine);
    // counter compare width: holds the clipped width and the width register
    localparam int CntW      = (AddrW + 1 > 11) ? AddrW + 1 : 11;
    localparam int AccW      = 28;
    localparam int MagW      = 28;
    localparam int PixW      = 24;
    localparam int SatBit    = 8;

    typedef enum logic [2:0] {
        RegImageWidth    = 3'd0,
        RegImageHeight   = 3'd1,
        RegKernelWidth   = 3'd2,
        RegKernelHeight  = 3'd3,
        RegWeightsTop    = 3'd4,
        RegWeightsMiddle = 3'd5,
        RegWeightsBottom = 3'd6,
        RegWeightTotal   = 3'd7
    } rck_reg_t;

    typedef struct packed {
        logic       capture;
        logic       shift;
        logic       mac_clear;
        logic       mac_en;
        logic [1:0] tap_row;
        logic [1:0] tap_col;
        logic       div_init;
        logic       div_step;
        logic [3:0] div_bit;
        logic       out_load;
    } rck_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } rck_status_t;

    function automatic logic [1:0] kern_eff(input logic [1:0] k);
        logic [1:0] r;
        r = (k == 2'd0) ? 2'd1 : k;
        if (r > 2'(MaxKernel))
        begin
            r = 2'(MaxKernel);
        end
        return r;
    endfunction

endpackage

/* src/rck_pixel_if.sv */
interface rck_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

/* src/rck_result_if.sv */
interface rck_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output row_end, output frame_end, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input row_end, input frame_end, output ready);
endinterface

/* src/rgb_kernel_convolution_clamp.sv */
// Streaming RGB 3x3 convolution with normalization and clamping. Pixels enter in raster
// order on the pixel channel; for every pixel that completes a kernel window (window
// anchored at its top-left input pixel, valid region only) one filtered pixel leaves on
// the result channel, with row_end and frame_end marking the end of an output row and
// frame. Weights are signed Q8.8 lanes, each channel sum is divided by weight_total
// truncating toward zero (a zero total divides by 256) and clamped to 0..255. Steps:
// a pixel that yields no result goes through a line store read, then the window and line
// store update; a pixel that yields a result also has the single tap multiplier bank walk
// the nine window taps and the bit-serial quotient unit take one saturation check and
// eight quotient bits before the result load. A finished result waits in the output
// register while the next pixel is taken; only its own final load waits for that
// register to drain. Configuration writes are taken at any cycle and must be issued
// only while no transaction is in flight.
module rgb_kernel_convolution_clamp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 write_en,
    input  logic [2:0]           write_index,
    input  logic [47:0]          write_data,
    rck_pixel_if.sink            pixel,
    rck_result_if.source         result
);
    rck_pkg::rck_cmd_t    cmd;
    rck_pkg::rck_status_t status;

    // sequencer: accept, line update, tap walk, divide, load result
    rck_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // line stores, window, accumulators, divider and output register
    rck_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .red_in      (pixel.red_in),
        .green_in    (pixel.green_in),
        .blue_in     (pixel.blue_in),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .red_out     (result.red_out),
        .green_out   (result.green_out),
        .blue_out    (result.blue_out),
        .row_end     (result.row_end),
        .frame_end   (result.frame_end)
    );
endmodule

/* src/rck_ram.sv */
module rck_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* src/rck_ctrl.sv */
module rck_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rck_pkg::rck_status_t status,
    output rck_pkg::rck_cmd_t    cmd
);
    typedef enum logic [2:0] {IDLE, LOAD, MAC, PREP, DIV, DONE} state_t;

    state_t     state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic [3:0] bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.tap_row = row_reg;
        cmd.tap_col = col_reg;
        cmd.div_bit = bit_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = LOAD;
                end
            end
            LOAD:
            begin
                cmd.shift     = 1'b1;
                cmd.mac_clear = 1'b1;
                row_next      = '0;
                col_next      = '0;
                state_next    = status.emit ? MAC : IDLE;
            end
            MAC:
            begin
                cmd.mac_en = 1'b1;
                if (col_reg == 2'd2)
                begin
                    col_next = '0;
                    if (row_reg == 2'd2)
                    begin
                        state_next = PREP;
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                    end
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            PREP:
            begin
                cmd.div_init = 1'b1;
                bit_next     = 4'(rck_pkg::SatBit);
                state_next   = DIV;
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = DONE;
                end
                else
                begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end
endmodule

/* src/rck_datapath.sv */
module rck_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 write_en,
    input  logic [2:0]           write_index,
    input  logic [47:0]          write_data,
    input  logic [7:0]           red_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           blue_in,
    input  rck_pkg::rck_cmd_t    cmd,
    output rck_pkg::rck_status_t status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           red_out,
    output logic [7:0]           green_out,
    output logic [7:0]           blue_out,
    output logic                 row_end,
    output logic                 frame_end
);
    localparam int AddrW = rck_pkg::AddrW;
    localparam int CntW  = rck_pkg::CntW;
    localparam int AccW  = rck_pkg::AccW;
    localparam int MagW  = rck_pkg::MagW;
    localparam int PixW  = rck_pkg::PixW;

    // configuration
    logic [10:0]        width_reg;
    logic [11:0]        height_reg;
    logic [1:0]         kw_reg, kh_reg;
    logic [47:0]        wt_top_reg, wt_mid_reg, wt_bot_reg;
    logic signed [19:0] total_reg;

    // counters and flags
    logic [AddrW-1:0] col_reg;
    logic [11:0]      row_reg;
    logic             row_last_reg, frame_last_reg;

    // pixel, window, accumulators, divider
    logic [PixW-1:0]        pix_reg;
    logic [PixW-1:0]        win_reg [3][3];
    logic signed [AccW-1:0] acc_reg [3];
    logic [MagW-1:0]        rem_reg [3];
    logic [7:0]             q_reg [3];
    logic [2:0]             neg_reg, sat_reg;
    logic [19:0]            den_reg;

    logic              out_valid_reg;
    logic [7:0]        out_ch_reg [3];
    logic              row_end_reg, frame_end_reg;

    logic [PixW-1:0] above1, above2;

    rck_ram #(.Width(PixW), .Depth(rck_pkg::MaxLine)) u_line1 (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (col_reg),
        .wdata (pix_reg),
        .re    (cmd.capture),
        .raddr (col_reg),
        .rdata (above1)
    );

    rck_ram #(.Width(PixW), .Depth(rck_pkg::MaxLine)) u_line2 (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (col_reg),
        .wdata (above1),
        .re    (cmd.capture),
        .raddr (col_reg),
        .rdata (above2)
    );

    // position decode
    logic [1:0]      kw, kh;
    logic [CntW-1:0] w_ext, weff, c_ext, c1;
    logic [11:0]     heff;
    logic [12:0]     r1;
    logic            row_last, frame_last;

    always_comb
    begin
        kw    = rck_pkg::kern_eff(kw_reg);
        kh    = rck_pkg::kern_eff(kh_reg);
        w_ext = CntW'(width_reg);
        weff  = (w_ext > CntW'(rck_pkg::MaxLine)) ? CntW'(rck_pkg::MaxLine) : w_ext;
        if (weff == '0)
        begin
            weff = CntW'(1);
        end
        heff  = (height_reg == '0) ? 12'd1 : height_reg;
        c_ext = CntW'(col_reg);
        c1    = c_ext + CntW'(1);
        r1    = 13'(row_reg) + 13'd1;
        row_last   = (c1 >= weff);
        frame_last = row_last && (r1 >= 13'(heff));
        status.emit = (c_ext < weff) && (row_reg < heff)
                    && (c1 >= CntW'(kw)) && (r1 >= 13'(kh));
        status.out_free = !out_valid_reg || out_ready;
    end

    // tap weight and products
    logic [2:0]         row_sum, col_sum;
    logic [1:0]         kr, kc;
    logic               used;
    logic [47:0]        wrow;
    logic signed [15:0] wt;
    logic [PixW-1:0]    tap_pix;
    logic signed [24:0] prod [3];

    always_comb
    begin
        row_sum = 3'(cmd.tap_row) + 3'(kh);
        col_sum = 3'(cmd.tap_col) + 3'(kw);
        used    = (row_sum >= 3'd3) && (col_sum >= 3'd3);
        kr      = 2'(row_sum - 3'd3);
        kc      = 2'(col_sum - 3'd3);
        case (kr)
            2'd0:    wrow = wt_top_reg;
            2'd1:    wrow = wt_mid_reg;
            default: wrow = wt_bot_reg;
        endcase
        case (kc)
            2'd0:    wt = $signed(wrow[15:0]);
            2'd1:    wt = $signed(wrow[31:16]);
            default: wt = $signed(wrow[47:32]);
        endcase
        if (!used)
        begin
            wt = '0;
        end
        tap_pix = win_reg[cmd.tap_row][cmd.tap_col];
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = wt * $signed({1'b0, tap_pix[8*ch +: 8]});
        end
    end

    // divider step
    logic [MagW-1:0] shifted;
    logic [2:0]      ge;

    always_comb
    begin
        shifted = MagW'(den_reg) << cmd.div_bit;
        for (int ch = 0; ch < 3; ch++)
        begin
            ge[ch] = (rem_reg[ch] >= shifted);
        end
    end

    // control state: configuration, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 11'd640;
            height_reg    <= 12'd480;
            kw_reg        <= 2'd3;
            kh_reg        <= 2'd3;
            wt_top_reg    <= '0;
            wt_mid_reg    <= 48'h000001000000;
            wt_bot_reg    <= '0;
            total_reg     <= 20'sd256;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (write_en)
            begin
                unique case (rck_pkg::rck_reg_t'(write_index))
                    rck_pkg::RegImageWidth:    width_reg  <= write_data[10:0];
                    rck_pkg::RegImageHeight:   height_reg <= write_data[11:0];
                    rck_pkg::RegKernelWidth:   kw_reg     <= write_data[1:0];
                    rck_pkg::RegKernelHeight:  kh_reg     <= write_data[1:0];
                    rck_pkg::RegWeightsTop:    wt_top_reg <= write_data;
                    rck_pkg::RegWeightsMiddle: wt_mid_reg <= write_data;
                    rck_pkg::RegWeightsBottom: wt_bot_reg <= write_data;
                    rck_pkg::RegWeightTotal:   total_reg  <= $signed(write_data[19:0]);
                    default: ;
                endcase
            end
            if (cmd.shift)
            begin
                if (row_last)
                begin
                    col_reg <= '0;
                    row_reg <= frame_last ? 12'd0 : 12'(r1);
                end
                else
                begin
                    col_reg <= AddrW'(c1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= {blue_in, green_in, red_in};
        end
        if (cmd.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2]  <= above2;
            win_reg[1][2]  <= above1;
            win_reg[2][2]  <= pix_reg;
            row_last_reg   <= row_last;
            frame_last_reg <= frame_last;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (cmd.mac_clear)
            begin
                acc_reg[ch] <= '0;
            end
            else if (cmd.mac_en)
            begin
                acc_reg[ch] <= acc_reg[ch] + AccW'(prod[ch]);
            end
            if (cmd.div_init)
            begin
                rem_reg[ch] <= acc_reg[ch][AccW-1] ? MagW'(-acc_reg[ch]) : MagW'(acc_reg[ch]);
                neg_reg[ch] <= acc_reg[ch][AccW-1] ^ total_reg[19];
                sat_reg[ch] <= 1'b0;
                q_reg[ch]   <= '0;
            end
            else if (cmd.div_step)
            begin
                if (cmd.div_bit == 4'(rck_pkg::SatBit))
                begin
                    sat_reg[ch] <= ge[ch];
                end
                else if (ge[ch])
                begin
                    rem_reg[ch] <= rem_reg[ch] - shifted;
                    q_reg[ch][cmd.div_bit[2:0]] <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_ch_reg[ch] <= neg_reg[ch] ? 8'd0 : (sat_reg[ch] ? 8'd255 : q_reg[ch]);
            end
        end
        if (cmd.div_init)
        begin
            // a zero total divides by 256 instead
            den_reg <= (total_reg == '0) ? 20'd256
                     : (total_reg[19] ? 20'(-total_reg) : 20'(total_reg));
        end
        if (cmd.out_load)
        begin
            row_end_reg   <= row_last_reg;
            frame_end_reg <= frame_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_ch_reg[0];
    assign green_out = out_ch_reg[1];
    assign blue_out  = out_ch_reg[2];
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;
endmodule
